// ===== sv/assert_macros.svh =====
// assertion macros used by the heap queue rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge while out of reset
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("heap queue assertion failed");
// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("heap queue assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== sv/bmhq_pkg.sv =====
// shared types and constants of the binary min-heap queue
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int IDX_W = ADDR_W + 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ENT_W = KEY_W + TAG_W;
  localparam int IN_DATA_W = ((ENT_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 2 * ENT_W + CNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int STATUS_W = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_POP_RD,
    S_POP_LD,
    S_SWIM_RD,
    S_SWIM_CMP,
    S_SINK_RD,
    S_SINK_CMP,
    S_WRITE,
    S_TOP_RD,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic start;
    logic rd_pop;
    logic ld_pop;
    logic rd_parent;
    logic swim_swap;
    logic rd_child;
    logic sink_swap;
    logic write_cur;
    logic rd_top;
    logic out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic at_root;
    logic no_child;
    logic swim_less;
    logic sink_stop;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/binary_min_heap_queue.sv =====
// binary min-heap priority queue of (key, tag) entries ordered by key
//
// one request enters on s_axis: tuser selects push (0) or pop (1), tdata carries
// the key and tag to push. every request gives exactly one result on m_axis:
// tuser holds the status (ok, push dropped on a full heap, pop on an empty
// heap), tdata the popped entry, the new root entry, the count and an empty flag.
// requests are handled one at a time; s_axis_tready is high only while idle.
// a push goes through start, then a read and a compare per level as the entry
// swims up, then write, top read and done; a pop adds a read and a load of the
// root and last entries before it sinks down. an entry moves at most 8 levels.
// a dropped push or an empty pop goes from start straight to top read and done,
// and a new request can be taken in the cycle after the result is loaded.
// the time per request is set by the sift loop: each level is one read step of
// the single entry memory followed by one compare and write-back.
// the result sits in an output register, so a new request is taken while an
// older result still waits; a stalled m_axis_tready holds the result and the
// next request then waits at its last step until the register frees.
// rst clears the entry count and drops any pending result; the entry memory
// itself is not cleared, and data of slots at or above the count is never used.
// depends on bmhq_pkg, bmhq_ctrl and bmhq_dpath
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue import bmhq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, tag
  input  logic                  s_axis_tuser,   // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // popped_key, popped_tag, top_key,
                                                // top_tag, count, empty_res
  output logic [STATUS_W-1:0]   m_axis_tuser    // status
);

  ctl_t ctl;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bmhq_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .in_data (s_axis_tdata),
    .in_user (s_axis_tuser),
    .tvalid  (m_axis_tvalid),
    .tready  (m_axis_tready),
    .tdata   (m_axis_tdata),
    .tuser   (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== sv/bmhq_ctrl.sv =====
// sequencer of the heap queue: walks one request through push or pop
// depends on bmhq_pkg; drives the datapath through ctl_t, reads sts_t
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl import bmhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if (sts.is_pop) begin
          state_next = sts.empty ? S_TOP_RD : S_POP_RD;
        end else begin
          state_next = sts.full ? S_TOP_RD : S_SWIM_RD;
        end
      end
      S_POP_RD:   state_next = S_POP_LD;
      S_POP_LD:   state_next = S_SINK_RD;
      S_SWIM_RD:  state_next = sts.at_root ? S_WRITE : S_SWIM_CMP;
      S_SWIM_CMP: state_next = sts.swim_less ? S_SWIM_RD : S_WRITE;
      S_SINK_RD:  state_next = sts.no_child ? S_WRITE : S_SINK_CMP;
      S_SINK_CMP: state_next = sts.sink_stop ? S_WRITE : S_SINK_RD;
      S_WRITE:    state_next = S_TOP_RD;
      S_TOP_RD:   state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_START:    ctl.start = 1'b1;
      S_POP_RD:   ctl.rd_pop = 1'b1;
      S_POP_LD:   ctl.ld_pop = 1'b1;
      S_SWIM_RD:  ctl.rd_parent = !sts.at_root;
      S_SWIM_CMP: ctl.swim_swap = sts.swim_less;
      S_SINK_RD:  ctl.rd_child = !sts.no_child;
      S_SINK_CMP: ctl.sink_swap = !sts.sink_stop;
      S_WRITE:    ctl.write_cur = 1'b1;
      S_TOP_RD:   ctl.rd_top = 1'b1;
      S_DONE:     ctl.out_load = sts.out_free;
      default:    ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/bmhq_dpath.sv =====
// heap storage, sift registers, entry count and result register
// depends on bmhq_pkg and assert_macros.svh; steered by bmhq_ctrl
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmhq_dpath import bmhq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_user,
  output logic                  tvalid,
  input  logic                  tready,
  output logic [OUT_DATA_W-1:0] tdata,
  output logic [STATUS_W-1:0]   tuser
);

  entry_t mem [CAPACITY];

  logic             op_pop;
  entry_t           in_ent;
  entry_t           cur;
  entry_t           popped;
  entry_t           rd_a;
  entry_t           rd_b;
  logic [CNT_W-1:0] count;
  logic [ADDR_W-1:0] pos;
  status_t          status;

  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  c0;
  logic [IDX_W:0]    c1;
  logic              c1_ok;
  logic              pick_right;
  entry_t            child;
  logic [ADDR_W-1:0] child_idx;
  entry_t            top;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              ra_en;
  logic [ADDR_W-1:0] ra_addr;
  logic              rb_en;
  logic [ADDR_W-1:0] rb_addr;

  assign parent = (pos - ADDR_W'(1)) >> 1;
  assign c0 = {pos, 1'b1};
  assign c1 = {1'b0, c0} + (IDX_W + 1)'(1);
  assign c1_ok = c1 < (IDX_W + 1)'(count);
  // right child wins when it exists, unless the left key is strictly smaller
  assign pick_right = c1_ok && !(rd_a.key < rd_b.key);
  assign child = pick_right ? rd_b : rd_a;
  assign child_idx = pick_right ? c1[ADDR_W-1:0] : c0[ADDR_W-1:0];
  assign top = (count != '0) ? rd_a : '0;

  always_comb begin
    sts.is_pop    = op_pop;
    sts.full      = count == CNT_W'(CAPACITY);
    sts.empty     = count == '0;
    sts.at_root   = pos == '0;
    sts.no_child  = !(c0 < IDX_W'(count));
    sts.swim_less = cur.key < rd_a.key;
    sts.sink_stop = cur.key < child.key;
    sts.out_free  = !tvalid || tready;
  end

  // one write and two reads per cycle at most
  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos;
    wr_data = cur;
    ra_en = 1'b0;
    ra_addr = '0;
    rb_en = 1'b0;
    rb_addr = '0;
    if (ctl.swim_swap) begin
      wr_en = 1'b1;
      wr_data = rd_a;
    end
    if (ctl.sink_swap) begin
      wr_en = 1'b1;
      wr_data = child;
    end
    if (ctl.write_cur) wr_en = 1'b1;
    if (ctl.rd_pop) begin
      ra_en = 1'b1;
      rb_en = 1'b1;
      rb_addr = ADDR_W'(count - CNT_W'(1));
    end
    if (ctl.rd_parent) begin
      ra_en = 1'b1;
      ra_addr = parent;
    end
    if (ctl.rd_child) begin
      ra_en = 1'b1;
      ra_addr = c0[ADDR_W-1:0];
      rb_en = 1'b1;
      rb_addr = c1[ADDR_W-1:0];
    end
    if (ctl.rd_top) ra_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ra_en) rd_a <= mem[ra_addr];
    if (rb_en) rd_b <= mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_pop <= in_user;
      in_ent.key <= in_data[KEY_W-1:0];
      in_ent.tag <= in_data[KEY_W +: TAG_W];
    end
    if (ctl.start) begin
      popped <= '0;
      pos <= count[ADDR_W-1:0];
      cur <= in_ent;
      if (op_pop) begin
        status <= (count == '0) ? ST_EMPTY : ST_OK;
      end else begin
        status <= (count == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
      end
    end
    if (ctl.ld_pop) begin
      popped <= rd_a;
      cur <= rd_b;
      pos <= '0;
    end
    if (ctl.swim_swap) pos <= parent;
    if (ctl.sink_swap) pos <= child_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.write_cur) begin
      count <= op_pop ? count - CNT_W'(1) : count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      tuser <= status;
      tdata <= {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, (count == '0), count,
                top.tag, top.key, popped.tag, popped.key};
    end
  end

  `ASSERT_RST(a_count_max, clk, rst, count <= CNT_W'(CAPACITY))
  `ASSERT_RST(a_push_room, clk, rst, ctl.write_cur && !op_pop |-> count < CNT_W'(CAPACITY))
  `ASSERT_RST(a_pop_held, clk, rst, ctl.ld_pop |-> count != '0)
  `ASSERT_RST(a_out_shown, clk, rst, ctl.out_load |=> tvalid)
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (!tvalid && count == '0))

endmodule

`default_nettype wire
